@@ hw/rtl/wavhp_pkg.sv @@
package wavhp_pkg;

    localparam int unsigned POS_W = 33;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] WAV_MIN_LEN   = 32'd44;
    localparam logic [31:0] FMT_MIN       = 32'd16;
    localparam logic [31:0] MIN_TAG_LEN   = 32'd4;
    localparam logic [31:0] HEAD_TAIL     = 32'd7;
    localparam logic [15:0] UNSIGNED_BITS = 16'd8;

    localparam logic [POS_W-1:0] WALK_START = POS_W'(12);
    localparam logic [POS_W-1:0] HEAD_LEN   = POS_W'(8);
    localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] TAG_END    = POS_W'(3);

    localparam logic [3:0] ST_OK_AUDIO   = 4'd0;
    localparam logic [3:0] ST_OK_EMPTY   = 4'd1;
    localparam logic [3:0] ST_LOAD_FAIL  = 4'd2;
    localparam logic [3:0] ST_UNDER_4    = 4'd3;
    localparam logic [3:0] ST_NOT_RIFF   = 4'd4;
    localparam logic [3:0] ST_TOO_SHORT  = 4'd5;
    localparam logic [3:0] ST_BAD_FMT    = 4'd6;
    localparam logic [3:0] ST_NO_FMT     = 4'd7;
    localparam logic [3:0] ST_NO_DATA    = 4'd8;

    typedef struct packed {
        logic [7:0]  file_byte;
        logic [31:0] file_length;
        logic        load_failed;
        logic        end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] sample_bits;
        logic        samples_signed;
        logic [31:0] audio_offset;
        logic [31:0] audio_length;
    } out_item_t;

endpackage

@@ hw/rtl/wavhp_parse_core.sv @@
module wavhp_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  wavhp_pkg::in_item_t  item,
    output logic                 verdict_hit,
    output wavhp_pkg::out_item_t verdict
);

    typedef enum logic [3:0] {
        PH_RIFF = 4'b0001,
        PH_SKIP = 4'b0010,
        PH_HEAD = 4'b0100,
        PH_FMT  = 4'b1000
    } phase_t;

    localparam int unsigned PW = wavhp_pkg::POS_W;

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] chunk_reg, chunk_next;
    logic [PW-1:0] body_reg, body_next;
    logic [PW-1:0] limit_reg, limit_next;
    phase_t        phase_reg, phase_next;
    logic [4:0]    rel_reg, rel_next;
    logic [31:0]   shift_reg, shift_next;
    logic [31:0]   tag_reg, tag_next;
    logic [31:0]   fmt_len_reg, fmt_len_next;
    logic          fmt_seen_reg, fmt_seen_next;
    logic [15:0]   format_reg, format_next;
    logic [15:0]   channels_reg, channels_next;
    logic [31:0]   rate_reg, rate_next;
    logic [31:0]   byte_rate_reg, byte_rate_next;
    logic [15:0]   bits_reg, bits_next;
    logic          done_reg, done_next;
    logic [31:0]   flen_reg, flen_next;

    logic [31:0]   shift_new;
    logic [4:0]    cur_rel;
    logic [PW-1:0] chunk_sum;
    logic [PW-1:0] chunk_sum8;
    logic [PW-1:0] fmt_end;
    logic [PW-1:0] fmt_end8;
    logic [PW-1:0] flen_wide;
    logic          at_chunk;
    logic          data_cut;
    logic          data_empty;
    logic [3:0]    v_status;
    logic [31:0]   v_offset;
    logic [31:0]   v_length;

    always_comb
    begin
        shift_new  = {item.file_byte, shift_reg[31:8]};
        cur_rel    = (phase_reg == PH_SKIP) ? 5'd0 : rel_reg;
        flen_wide  = {1'b0, flen_reg};
        chunk_sum  = body_reg + {1'b0, shift_new};
        chunk_sum8 = body_reg + {1'b0, shift_new} + wavhp_pkg::HEAD_LEN;
        fmt_end    = body_reg + {1'b0, fmt_len_reg};
        fmt_end8   = body_reg + {1'b0, fmt_len_reg} + wavhp_pkg::HEAD_LEN;
        at_chunk   = (pos_reg == chunk_reg);
        data_cut   = (chunk_sum > flen_wide);
        data_empty = (shift_new == 32'd0) || (body_reg == flen_wide);

        pos_next       = pos_reg;
        chunk_next     = chunk_reg;
        body_next      = body_reg;
        limit_next     = limit_reg;
        phase_next     = phase_reg;
        rel_next       = rel_reg;
        shift_next     = shift_reg;
        tag_next       = tag_reg;
        fmt_len_next   = fmt_len_reg;
        fmt_seen_next  = fmt_seen_reg;
        format_next    = format_reg;
        channels_next  = channels_reg;
        rate_next      = rate_reg;
        byte_rate_next = byte_rate_reg;
        bits_next      = bits_reg;
        done_next      = done_reg;
        flen_next      = flen_reg;

        verdict_hit = 1'b0;
        v_status    = wavhp_pkg::ST_NO_DATA;
        v_offset    = 32'd0;
        v_length    = 32'd0;

        if (step)
        begin
            shift_next = shift_new;
            pos_next   = (pos_reg == wavhp_pkg::POS_MAX) ? pos_reg : pos_reg + PW'(1);
            rel_next   = cur_rel + 5'd1;

            if (pos_reg == '0)
            begin
                flen_next  = item.file_length;
                limit_next = (item.file_length < wavhp_pkg::HEAD_TAIL) ? '0 :
                             {1'b0, item.file_length - wavhp_pkg::HEAD_TAIL};
                if (item.load_failed)
                begin
                    verdict_hit = 1'b1;
                    v_status    = wavhp_pkg::ST_LOAD_FAIL;
                end
                else if (item.file_length < wavhp_pkg::MIN_TAG_LEN)
                begin
                    verdict_hit = 1'b1;
                    v_status    = wavhp_pkg::ST_UNDER_4;
                end
            end
            else if (!done_reg)
            begin
                case (phase_reg)
                    PH_RIFF:
                    begin
                        if (pos_reg == wavhp_pkg::TAG_END)
                        begin
                            if (shift_new != wavhp_pkg::TAG_RIFF)
                            begin
                                verdict_hit = 1'b1;
                                v_status    = wavhp_pkg::ST_NOT_RIFF;
                            end
                            else if (flen_reg <= wavhp_pkg::WAV_MIN_LEN)
                            begin
                                verdict_hit = 1'b1;
                                v_status    = wavhp_pkg::ST_TOO_SHORT;
                            end
                            else
                            begin
                                chunk_next = wavhp_pkg::WALK_START;
                                body_next  = wavhp_pkg::WALK_START + wavhp_pkg::HEAD_LEN;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP, PH_HEAD:
                    begin
                        if (phase_reg == PH_HEAD || at_chunk)
                        begin
                            phase_next = PH_HEAD;
                            if (cur_rel == 5'd3)
                            begin
                                tag_next = shift_new;
                                if (shift_new == wavhp_pkg::TAG_DATA && !fmt_seen_reg)
                                begin
                                    verdict_hit = 1'b1;
                                    v_status    = wavhp_pkg::ST_NO_FMT;
                                end
                            end
                            else if (cur_rel == 5'd7)
                            begin
                                if (tag_reg == wavhp_pkg::TAG_FMT && !fmt_seen_reg)
                                begin
                                    if (shift_new < wavhp_pkg::FMT_MIN ||
                                        chunk_sum >= flen_wide)
                                    begin
                                        verdict_hit = 1'b1;
                                        v_status    = wavhp_pkg::ST_BAD_FMT;
                                    end
                                    else
                                    begin
                                        fmt_len_next  = shift_new;
                                        fmt_seen_next = 1'b1;
                                        phase_next    = PH_FMT;
                                    end
                                end
                                else if (tag_reg == wavhp_pkg::TAG_DATA)
                                begin
                                    verdict_hit = 1'b1;
                                    v_status    = data_empty ? wavhp_pkg::ST_OK_EMPTY :
                                                               wavhp_pkg::ST_OK_AUDIO;
                                    v_offset    = body_reg[31:0];
                                    v_length    = data_cut ? flen_reg - body_reg[31:0] :
                                                             shift_new;
                                end
                                else
                                begin
                                    chunk_next = chunk_sum;
                                    body_next  = chunk_sum8;
                                    phase_next = PH_SKIP;
                                    if (chunk_sum >= limit_reg)
                                    begin
                                        verdict_hit = 1'b1;
                                        v_status    = wavhp_pkg::ST_NO_DATA;
                                    end
                                end
                            end
                        end
                    end
                    PH_FMT:
                    begin
                        case (cur_rel)
                            5'd9:  format_next    = shift_new[31:16];
                            5'd11: channels_next  = shift_new[31:16];
                            5'd15: rate_next      = shift_new;
                            5'd19: byte_rate_next = shift_new;
                            5'd23:
                            begin
                                bits_next  = shift_new[31:16];
                                chunk_next = fmt_end;
                                body_next  = fmt_end8;
                                phase_next = PH_SKIP;
                                if (fmt_end >= limit_reg)
                                begin
                                    verdict_hit = 1'b1;
                                    v_status    = wavhp_pkg::ST_NO_DATA;
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end

            if (verdict_hit)
            begin
                done_next = 1'b1;
            end

            if (item.end_of_file)
            begin
                if (!done_reg && !verdict_hit)
                begin
                    verdict_hit = 1'b1;
                    v_status    = (pos_reg < wavhp_pkg::TAG_END) ? wavhp_pkg::ST_UNDER_4 :
                                                                 wavhp_pkg::ST_NO_DATA;
                end
                pos_next       = '0;
                chunk_next     = wavhp_pkg::WALK_START;
                body_next      = wavhp_pkg::WALK_START + wavhp_pkg::HEAD_LEN;
                limit_next     = '0;
                phase_next     = PH_RIFF;
                rel_next       = 5'd0;
                shift_next     = 32'd0;
                tag_next       = 32'd0;
                fmt_len_next   = 32'd0;
                fmt_seen_next  = 1'b0;
                format_next    = 16'd0;
                channels_next  = 16'd1;
                rate_next      = 32'd0;
                byte_rate_next = 32'd0;
                bits_next      = 16'd0;
                done_next      = 1'b0;
                flen_next      = 32'd0;
            end
        end

        verdict = '0;
        verdict.status = v_status;
        if (v_status inside {wavhp_pkg::ST_OK_AUDIO, wavhp_pkg::ST_OK_EMPTY})
        begin
            verdict.audio_format   = format_reg;
            verdict.channel_count  = channels_reg;
            verdict.sample_rate    = rate_reg;
            verdict.byte_rate      = byte_rate_reg;
            verdict.sample_bits    = bits_reg;
            verdict.samples_signed = (bits_reg != wavhp_pkg::UNSIGNED_BITS);
            verdict.audio_offset   = v_offset;
            verdict.audio_length   = v_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            chunk_reg     <= wavhp_pkg::WALK_START;
            body_reg      <= wavhp_pkg::WALK_START + wavhp_pkg::HEAD_LEN;
            limit_reg     <= '0;
            phase_reg     <= PH_RIFF;
            rel_reg       <= 5'd0;
            shift_reg     <= 32'd0;
            tag_reg       <= 32'd0;
            fmt_len_reg   <= 32'd0;
            fmt_seen_reg  <= 1'b0;
            format_reg    <= 16'd0;
            channels_reg  <= 16'd1;
            rate_reg      <= 32'd0;
            byte_rate_reg <= 32'd0;
            bits_reg      <= 16'd0;
            done_reg      <= 1'b0;
            flen_reg      <= 32'd0;
        end
        else
        begin
            pos_reg       <= pos_next;
            chunk_reg     <= chunk_next;
            body_reg      <= body_next;
            limit_reg     <= limit_next;
            phase_reg     <= phase_next;
            rel_reg       <= rel_next;
            shift_reg     <= shift_next;
            tag_reg       <= tag_next;
            fmt_len_reg   <= fmt_len_next;
            fmt_seen_reg  <= fmt_seen_next;
            format_reg    <= format_next;
            channels_reg  <= channels_next;
            rate_reg      <= rate_next;
            byte_rate_reg <= byte_rate_next;
            bits_reg      <= bits_next;
            done_reg      <= done_next;
            flen_reg      <= flen_next;
        end
    end

    a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !verdict_hit)
        else $error("second verdict within one file");

    a_verdict_latches: assert property (@(posedge clk) disable iff (!rst_n)
        step && verdict_hit && !item.end_of_file |=> done_reg)
        else $error("verdict did not close the file");

    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.end_of_file |=> pos_reg == '0 && !done_reg && phase_reg == PH_RIFF)
        else $error("parser did not restart after end of file");

endmodule

@@ hw/rtl/wavhp_out_buffer.sv @@
module wavhp_out_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wavhp_pkg::out_item_t push_item,
    output logic                 space,
    output logic                 verdict_valid,
    input  logic                 verdict_ready,
    output wavhp_pkg::out_item_t verdict_item
);

    logic [1:0]           count_reg;
    wavhp_pkg::out_item_t head_reg;
    wavhp_pkg::out_item_t tail_reg;
    logic                 pop;

    assign verdict_valid = (count_reg != 2'd0);
    assign verdict_item  = head_reg;
    assign pop           = verdict_valid && verdict_ready;
    assign space         = (count_reg != 2'd2) || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            case (count_reg)
                2'd0:
                begin
                    if (push)
                    begin
                        count_reg <= 2'd1;
                    end
                end
                2'd1:
                begin
                    if (pop && !push)
                    begin
                        count_reg <= 2'd0;
                    end
                    else if (push && !pop)
                    begin
                        count_reg <= 2'd2;
                    end
                end
                2'd2:
                begin
                    if (pop && !push)
                    begin
                        count_reg <= 2'd1;
                    end
                end
                default: count_reg <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_reg <= push_item;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_reg <= push_item;
                end
                else if (push)
                begin
                    tail_reg <= push_item;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_reg <= tail_reg;
                    if (push)
                    begin
                        tail_reg <= push_item;
                    end
                end
            end
            default: ;
        endcase
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2 || pop)
        else $error("verdict pushed into a full buffer");

endmodule

@@ hw/rtl/wav_header_chunk_parser.sv @@
// WAV header parser. A file enters on the file channel one byte per request,
// each request carrying the byte, the total file length, the load-failure
// flag and an end-of-file mark on the last byte. The length and the flag
// are taken from the first byte of each file. For every file exactly one
// verdict leaves on the verdict channel, on the byte where it is decided:
// a status code, the fields of the first fmt chunk and the audio offset and
// length of the data chunk. After end of file the parser starts over.
// Throughput is one byte per cycle while the verdict buffer has space; each
// byte only updates counters, a four-byte shift register and a few compares
// on 33-bit chunk positions. An accepted byte waits in the input register
// until the verdict buffer has space, and is then parsed. Reset empties the
// input register and the verdict buffer and clears all parse state, so the
// next byte accepted is taken as the first byte of a file. A two-entry
// verdict buffer parts the two sides: while the receiver stalls, bytes keep
// flowing until both entries hold unread verdicts; then parsing halts and
// file_ready drops once the input register fills, until a verdict is taken.
module wav_header_chunk_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 file_valid,
    output logic                 file_ready,
    input  wavhp_pkg::in_item_t  file_item,
    output logic                 verdict_valid,
    input  logic                 verdict_ready,
    output wavhp_pkg::out_item_t verdict_item
);

    logic                 stage_valid_reg;
    wavhp_pkg::in_item_t  stage_item_reg;
    logic                 space;
    logic                 step;
    logic                 hit;
    wavhp_pkg::out_item_t result;

    assign step       = stage_valid_reg && space;
    assign file_ready = !stage_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (file_valid && file_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (file_valid && file_ready)
        begin
            stage_item_reg <= file_item;
        end
    end

    wavhp_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (stage_item_reg),
        .verdict_hit (hit),
        .verdict     (result)
    );

    wavhp_out_buffer u_buffer (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (step && hit),
        .push_item     (result),
        .space         (space),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_item  (verdict_item)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int LONG_HOLD   = 400;
    localparam int STUCK_LIMIT = 4000;
    localparam int TAIL_CYCLES = 20;

    typedef enum logic [3:0] {
        WALK_RIFF = 4'b0001,
        WALK_SKIP = 4'b0010,
        WALK_HEAD = 4'b0100,
        WALK_FMT  = 4'b1000
    } walk_phase_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 file_valid = 1'b0;
    logic                 file_ready;
    wavhp_pkg::in_item_t  file_item = '0;
    logic                 verdict_valid;
    logic                 verdict_ready = 1'b0;
    wavhp_pkg::out_item_t verdict_item;

    logic idle_on = 1'b1;
    logic hold_req = 1'b0;

    wavhp_pkg::in_item_t  bytes_to_send[$];
    wavhp_pkg::out_item_t verdicts_due[$];

    int          err_cnt = 0;
    int unsigned file_cnt = 0;
    int unsigned byte_cnt = 0;
    int unsigned checked_cnt = 0;
    bit [8:0]    codes_seen = '0;

    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_taken = 1'b0;
    int stuck_cnt = 0;

    // Parser state mirrored for prediction.
    logic [wavhp_pkg::POS_W-1:0] pos_cnt;
    logic [wavhp_pkg::POS_W-1:0] chunk_start;
    walk_phase_t                 walk_phase;
    logic [31:0]                 shift_reg;
    logic [31:0]                 chunk_id;
    logic [31:0]                 fmt_len;
    logic [15:0]                 fmt_code;
    logic [15:0]                 fmt_channels;
    logic [31:0]                 fmt_rate;
    logic [31:0]                 fmt_byte_rate;
    logic [15:0]                 fmt_bits;
    logic                        verdict_done;
    logic [31:0]                 held_len;

    wav_header_chunk_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .file_valid    (file_valid),
        .file_ready    (file_ready),
        .file_item     (file_item),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_item  (verdict_item)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic clear_parse();
        pos_cnt = '0;
        chunk_start = wavhp_pkg::WALK_START;
        walk_phase = WALK_RIFF;
        shift_reg = '0;
        chunk_id = '0;
        fmt_len = '0;
        fmt_code = '0;
        fmt_channels = 16'd1;
        fmt_rate = '0;
        fmt_byte_rate = '0;
        fmt_bits = '0;
        verdict_done = 1'b0;
        held_len = '0;
    endtask

    task automatic post_verdict(input logic [3:0] code, input logic [31:0] offs,
                                input logic [31:0] alen);
        wavhp_pkg::out_item_t v;
        v = '0;
        v.status = code;
        if (code == wavhp_pkg::ST_OK_AUDIO || code == wavhp_pkg::ST_OK_EMPTY)
        begin
            v.audio_format = fmt_code;
            v.channel_count = fmt_channels;
            v.sample_rate = fmt_rate;
            v.byte_rate = fmt_byte_rate;
            v.sample_bits = fmt_bits;
            v.samples_signed = (fmt_bits != wavhp_pkg::UNSIGNED_BITS);
            v.audio_offset = offs;
            v.audio_length = alen;
        end
        verdicts_due.push_back(v);
        verdict_done = 1'b1;
    endtask

    task automatic goto_chunk(input logic [63:0] start);
        chunk_start = start[wavhp_pkg::POS_W-1:0];
        walk_phase = WALK_SKIP;
        if (start + 64'd7 >= {32'd0, held_len})
            post_verdict(wavhp_pkg::ST_NO_DATA, '0, '0);
    endtask

    task automatic walk_byte(input logic [wavhp_pkg::POS_W-1:0] p);
        logic [wavhp_pkg::POS_W-1:0] rel;
        logic [63:0]                 body;
        logic [63:0]                 stop;
        logic [63:0]                 alen;
        logic [31:0]                 len;
        if (walk_phase == WALK_RIFF)
        begin
            if (p == wavhp_pkg::TAG_END)
            begin
                if (shift_reg != wavhp_pkg::TAG_RIFF)
                    post_verdict(wavhp_pkg::ST_NOT_RIFF, '0, '0);
                else if (held_len <= wavhp_pkg::WAV_MIN_LEN)
                    post_verdict(wavhp_pkg::ST_TOO_SHORT, '0, '0);
                else
                    goto_chunk({31'd0, wavhp_pkg::WALK_START});
            end
            return;
        end
        if (walk_phase == WALK_SKIP)
        begin
            if (p != chunk_start)
                return;
            walk_phase = WALK_HEAD;
        end
        if (p < chunk_start)
            return;
        rel = p - chunk_start;
        if (walk_phase == WALK_HEAD)
        begin
            if (rel == 3)
            begin
                chunk_id = shift_reg;
                if (chunk_id == wavhp_pkg::TAG_DATA && fmt_len == 0)
                    post_verdict(wavhp_pkg::ST_NO_FMT, '0, '0);
            end
            else if (rel == 7)
            begin
                len = shift_reg;
                body = {31'd0, chunk_start} + {31'd0, wavhp_pkg::HEAD_LEN};
                stop = body + {32'd0, len};
                if (chunk_id == wavhp_pkg::TAG_FMT && fmt_len == 0)
                begin
                    if (len < wavhp_pkg::FMT_MIN || stop >= {32'd0, held_len})
                    begin
                        post_verdict(wavhp_pkg::ST_BAD_FMT, '0, '0);
                    end
                    else
                    begin
                        fmt_len = len;
                        walk_phase = WALK_FMT;
                    end
                end
                else if (chunk_id == wavhp_pkg::TAG_DATA)
                begin
                    alen = (stop > {32'd0, held_len}) ? {32'd0, held_len} - body
                                                      : {32'd0, len};
                    post_verdict((alen != 0) ? wavhp_pkg::ST_OK_AUDIO : wavhp_pkg::ST_OK_EMPTY,
                                 body[31:0], alen[31:0]);
                end
                else
                begin
                    goto_chunk(stop);
                end
            end
            return;
        end
        case (rel)
            9: fmt_code = shift_reg[31:16];
            11: fmt_channels = shift_reg[31:16];
            15: fmt_rate = shift_reg;
            19: fmt_byte_rate = shift_reg;
            23:
            begin
                fmt_bits = shift_reg[31:16];
                stop = {31'd0, chunk_start} + {31'd0, wavhp_pkg::HEAD_LEN}
                       + {32'd0, fmt_len};
                goto_chunk(stop);
            end
            default: ;
        endcase
    endtask

    task automatic parse_byte(input wavhp_pkg::in_item_t it);
        logic [wavhp_pkg::POS_W-1:0] p;
        p = pos_cnt;
        shift_reg = {it.file_byte, shift_reg[31:8]};
        if (p == 0)
        begin
            held_len = it.file_length;
            if (it.load_failed)
                post_verdict(wavhp_pkg::ST_LOAD_FAIL, '0, '0);
            else if (it.file_length < wavhp_pkg::MIN_TAG_LEN)
                post_verdict(wavhp_pkg::ST_UNDER_4, '0, '0);
        end
        if (!verdict_done)
            walk_byte(p);
        if (pos_cnt != wavhp_pkg::POS_MAX)
            pos_cnt = pos_cnt + 1'b1;
        if (it.end_of_file)
        begin
            if (!verdict_done)
                post_verdict((pos_cnt < wavhp_pkg::MIN_TAG_LEN) ? wavhp_pkg::ST_UNDER_4
                                                               : wavhp_pkg::ST_NO_DATA,
                             '0, '0);
            clear_parse();
        end
    endtask

    function automatic void match_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
            err_cnt++;
        end
    endfunction

    task automatic check_verdict(input wavhp_pkg::out_item_t got);
        wavhp_pkg::out_item_t want;
        if (verdicts_due.size() == 0)
        begin
            $display("%0t: verdict with none expected, status %0d", $time, got.status);
            err_cnt++;
            return;
        end
        want = verdicts_due.pop_front();
        checked_cnt++;
        if (want.status <= wavhp_pkg::ST_NO_DATA)
            codes_seen[want.status] = 1'b1;
        match_field("status", want.status, got.status);
        match_field("audio_format", want.audio_format, got.audio_format);
        match_field("channel_count", want.channel_count, got.channel_count);
        match_field("sample_rate", want.sample_rate, got.sample_rate);
        match_field("byte_rate", want.byte_rate, got.byte_rate);
        match_field("sample_bits", want.sample_bits, got.sample_bits);
        match_field("samples_signed", want.samples_signed, got.samples_signed);
        match_field("audio_offset", want.audio_offset, got.audio_offset);
        match_field("audio_length", want.audio_length, got.audio_length);
    endtask

    task automatic put_u16(ref logic [7:0] img[$], input logic [15:0] w);
        img.push_back(w[7:0]);
        img.push_back(w[15:8]);
    endtask

    task automatic put_u32(ref logic [7:0] img[$], input logic [31:0] w);
        put_u16(img, w[15:0]);
        put_u16(img, w[31:16]);
    endtask

    task automatic put_rand(ref logic [7:0] img[$], input int n);
        repeat (n) img.push_back(8'($urandom));
    endtask

    task automatic add_junk(ref logic [7:0] img[$], input bit fmt_ok);
        int n;
        n = $urandom_range(0, 7);
        put_u32(img, (fmt_ok && $urandom_range(0, 4) == 0) ? wavhp_pkg::TAG_FMT
                                                           : 32'($urandom));
        put_u32(img, ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'(n));
        put_rand(img, n);
    endtask

    task automatic add_fmt(ref logic [7:0] img[$], input bit broken);
        logic [31:0] sz;
        int          body_n;
        int          pick;
        logic [15:0] bits_val;
        if (broken)
            sz = $urandom_range(0, 1) ? $urandom_range(0, 15) : (32'hFFFF_FFF0 | 32'($urandom));
        else
            sz = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24) : wavhp_pkg::FMT_MIN;
        body_n = (sz > 24) ? 16 : int'(sz);
        put_u32(img, wavhp_pkg::TAG_FMT);
        put_u32(img, sz);
        if (sz < wavhp_pkg::FMT_MIN)
        begin
            put_rand(img, body_n);
            return;
        end
        pick = $urandom_range(0, 4);
        bits_val = (pick == 0) ? wavhp_pkg::UNSIGNED_BITS : (pick == 1) ? 16'd16 :
                   (pick == 2) ? 16'd24 : (pick == 3) ? 16'd32 : 16'($urandom);
        put_u16(img, ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd1);
        put_u16(img, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8)));
        put_u32(img, $urandom);
        put_u32(img, $urandom);
        put_u16(img, 16'($urandom));
        put_u16(img, bits_val);
        put_rand(img, body_n - 16);
    endtask

    task automatic add_data(ref logic [7:0] img[$]);
        logic [31:0] dlen;
        int          pick;
        int          n;
        pick = $urandom_range(0, 5);
        dlen = (pick == 0) ? 32'd0 : (pick == 1) ? 32'($urandom) : $urandom_range(1, 12);
        put_u32(img, wavhp_pkg::TAG_DATA);
        put_u32(img, dlen);
        if (dlen > 8)
            n = $urandom_range(0, 8);
        else
            n = $urandom_range(0, 1) ? int'(dlen) : $urandom_range(0, dlen);
        put_rand(img, n);
    endtask

    task automatic send_file(ref logic [7:0] img[$], input logic [31:0] flen,
                             input bit fail);
        wavhp_pkg::in_item_t it;
        bit                  garble;
        garble = ($urandom_range(0, 6) == 0);
        foreach (img[i])
        begin
            it.file_byte = img[i];
            it.file_length = (i == 0 || !garble) ? flen : 32'($urandom);
            it.load_failed = (i == 0) ? fail : (garble && $urandom_range(0, 1));
            it.end_of_file = (i == img.size() - 1);
            bytes_to_send.push_back(it);
        end
        file_cnt++;
        byte_cnt += img.size();
    endtask

    task automatic make_wav();
        logic [7:0]  img[$];
        logic [31:0] flen;
        int          flaw;
        flaw = $urandom_range(0, 99);
        put_u32(img, (flaw < 4) ? (wavhp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)))
                                : wavhp_pkg::TAG_RIFF);
        put_rand(img, 8);
        repeat ($urandom_range(0, 2)) add_junk(img, 1'b0);
        if (flaw >= 4 && flaw < 8)
            add_data(img);
        add_fmt(img, flaw >= 12 && flaw < 16);
        repeat ($urandom_range(0, 1)) add_junk(img, 1'b1);
        if (flaw >= 8 && flaw < 12)
            add_junk(img, 1'b1);
        else
            add_data(img);
        if ($urandom_range(0, 4) == 0)
            put_rand(img, $urandom_range(1, 6));
        flen = img.size();
        if (flaw >= 20 && flaw < 24)
            flen = $urandom;
        else if (flaw >= 24 && flaw < 30)
            flen = flen + $urandom_range(0, 40) - 20;
        send_file(img, flen, flaw >= 16 && flaw < 20);
    endtask

    task automatic make_noise();
        logic [7:0]  img[$];
        logic [31:0] flen;
        if ($urandom_range(0, 2) == 0)
        begin
            put_u32(img, wavhp_pkg::TAG_RIFF);
            put_rand(img, $urandom_range(0, 8));
        end
        else
        begin
            put_rand(img, $urandom_range(1, 12));
        end
        flen = $urandom_range(0, 1) ? 32'($urandom) : $urandom_range(0, 60);
        send_file(img, flen, $urandom_range(0, 7) == 0);
    endtask

    task automatic random_file();
        if ($urandom_range(0, 6) == 0)
            make_noise();
        else
            make_wav();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_to_send.size() != 0 || file_valid || verdicts_due.size() != 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_valid <= 1'b0;
            file_item <= '0;
            gap_left = 0;
            clear_parse();
        end
        else
        begin
            if (file_valid && file_ready)
                parse_byte(file_item);
            if (!file_valid || file_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    file_valid <= 1'b0;
                end
                else if (idle_on && bytes_to_send.size() != 0
                         && $urandom_range(0, 11) == 0)
                begin
                    gap_left = $urandom_range(0, 10);
                    file_valid <= 1'b0;
                end
                else if (bytes_to_send.size() != 0)
                begin
                    file_item <= bytes_to_send.pop_front();
                    file_valid <= 1'b1;
                end
                else
                begin
                    file_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (verdict_valid && verdict_ready)
                check_verdict(verdict_item);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                verdict_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                verdict_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                verdict_ready <= 1'b0;
            end
            else
            begin
                verdict_ready <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((file_valid && file_ready) || (verdict_valid && verdict_ready)
                || (bytes_to_send.size() == 0 && !file_valid && verdicts_due.size() == 0))
                stuck_cnt = 0;
            else
                stuck_cnt++;
            if (stuck_cnt >= STUCK_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, STUCK_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] img[$];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        img = '{8'hFF};
        send_file(img, 32'hFFFF_FFFF, 1'b1);
        img = '{8'h00};
        send_file(img, 32'd0, 1'b0);
        img = '{8'h52, 8'h49, 8'h46};
        send_file(img, 32'd3, 1'b0);
        img = '{8'h52, 8'h49};
        send_file(img, 32'd1000, 1'b0);
        img = '{8'h52, 8'h49, 8'h46, 8'h46};
        send_file(img, wavhp_pkg::WAV_MIN_LEN, 1'b0);
        img = '{8'h52, 8'h49, 8'h46, 8'h58};
        send_file(img, 32'd100, 1'b0);
        img = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'hFF};
        send_file(img, 32'd45, 1'b0);

        while (byte_cnt < 500)
            random_file();
        wait_drained();

        idle_on <= 1'b0;
        hold_req <= 1'b1;
        repeat (20) make_noise();
        wait_drained();
        idle_on <= 1'b1;

        while (byte_cnt < 1150 || file_cnt < 45)
            random_file();
        wait_drained();

        idle_on <= 1'b0;
        while (byte_cnt < 1400 || file_cnt < 60)
            random_file();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Parsed %0d files in %0d bytes and checked %0d verdicts.",
                 file_cnt, byte_cnt, checked_cnt);
        $display("Saw %0d of 9 verdict codes, with one receiver hold of %0d cycles.",
                 $countones(codes_seen), LONG_HOLD);
        if (err_cnt == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/wavhp_pkg.sv
hw/rtl/wavhp_parse_core.sv
hw/rtl/wavhp_out_buffer.sv
hw/rtl/wav_header_chunk_parser.sv
tb/testbench.sv
